[hdl/ray_quadric_intersect_top_macros.svh]
// Assertion macros of the ray/quadric intersection top module.
`ifndef RAY_QUADRIC_INTERSECT_TOP_MACROS_SVH
`define RAY_QUADRIC_INTERSECT_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst is high
`define RQI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rqi: check failed");

// next-cycle implication
`define RQI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rqi: check failed");

`endif

[hdl/rqi_pkg.sv]
// Shared constants, codes and types of the ray/quadric intersection block.
package rqi_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int COORD_WIDTH_DEF = 32;

  localparam int COEF_W     = 62;   // clamped a, b, c
  localparam int MAG_W      = 61;   // |a|, |b|, |c|
  localparam int HALF_W     = 31;   // low half of a magnitude split
  localparam int PP_W       = 2 * HALF_W;
  localparam int PROD_W     = 122;  // b*b, a*c magnitudes
  localparam int DISC_W     = 127;  // exact b*b - 4ac
  localparam int RAD_W      = 126;  // sqrt operand
  localparam int ROOT_W     = 63;   // sqrt result
  localparam int SQ_REM_W   = 67;
  localparam int NUM_W      = 65;   // -b +/- sqrt
  localparam int NMAG_W     = 64;
  localparam int DEN_W      = 62;   // 2|a|
  localparam int OUT_DISC_W = 64;

  localparam logic signed [COEF_W-1:0] COEF_LIM = {1'b0, {(COEF_W-1){1'b1}}};

  typedef enum logic [1:0] {
    FUNC_SPHERE = 2'd0,
    FUNC_CYL    = 2'd1,
    FUNC_CONE   = 2'd2,
    FUNC_NONE   = 2'd3
  } rqi_func_t;

  // per-item data that rides along the sqrt and divide pipelines
  typedef struct packed {
    logic                           ok;
    logic signed [OUT_DISC_W-1:0]   disc;
    logic signed [COEF_W-1:0]       a;
    logic signed [COEF_W-1:0]       b;
  } rqi_side_t;

endpackage

[hdl/rqi_if.sv]
// Ray input and hit output channel interfaces.
interface rqi_ray_if #(parameter int COORD_WIDTH = rqi_pkg::COORD_WIDTH_DEF);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic signed [COORD_WIDTH-1:0] dir_x;
  logic signed [COORD_WIDTH-1:0] dir_y;
  logic signed [COORD_WIDTH-1:0] dir_z;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic signed [COORD_WIDTH-1:0] center_z;
  logic [COORD_WIDTH-2:0]        shape_radius;

  modport source (output valid, func, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  center_x, center_y, center_z, shape_radius, input ready);
  modport sink (input valid, func, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                center_x, center_y, center_z, shape_radius, output ready);
endinterface

interface rqi_hit_if #(parameter int COORD_WIDTH = rqi_pkg::COORD_WIDTH_DEF);
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic signed [COORD_WIDTH-1:0] t_near;
  logic signed [COORD_WIDTH-1:0] root_plus;
  logic signed [COORD_WIDTH-1:0] root_minus;
  logic signed [63:0]            discriminant;

  modport source (output valid, hit, t_near, root_plus, root_minus, discriminant,
                  input ready);
  modport sink (input valid, hit, t_near, root_plus, root_minus, discriminant,
                output ready);
endinterface

[hdl/rqi_sqrt.sv]
// Pipelined floor square root, one result bit per stage.
module rqi_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [rqi_pkg::RAD_W-1:0]   in_rad,
  input  rqi_pkg::rqi_side_t          in_side,
  output logic                        out_valid,
  output logic [rqi_pkg::ROOT_W-1:0]  out_root,
  output rqi_pkg::rqi_side_t          out_side
);
  import rqi_pkg::*;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
    logic [RAD_W-1:0]    rad;
  } sq_t;

  sq_t          st   [0:ROOT_W];
  rqi_side_t    side [0:ROOT_W];
  logic [ROOT_W:0] vld;

  // bring down two radicand bits, try (root << 2) | 1
  function automatic sq_t sq_step(sq_t s);
    logic [SQ_REM_W-1:0] r2;
    logic [SQ_REM_W-1:0] trial;
    sq_t                 n;
    r2    = {s.rem[SQ_REM_W-3:0], s.rad[RAD_W-1 -: 2]};
    trial = SQ_REM_W'({s.root, 2'b01});
    n.rad = s.rad << 2;
    if (r2 >= trial) begin
      n.rem  = r2 - trial;
      n.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = r2;
      n.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ROOT_W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0]   <= '{rem: '0, root: '0, rad: in_rad};
      side[0] <= in_side;
      for (int k = 0; k < ROOT_W; k++) begin
        st[k+1]   <= sq_step(st[k]);
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign out_root  = st[ROOT_W].root;
  assign out_side  = side[ROOT_W];

endmodule

[hdl/rqi_div.sv]
// Pipelined two-lane restoring divider for the root quotients.
module rqi_div #(
  parameter int COORD_WIDTH = rqi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rqi_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [1:0][rqi_pkg::NMAG_W-1:0]       in_mag,
  input  logic [1:0]                            in_neg,
  input  logic [rqi_pkg::DEN_W-1:0]             in_den,
  input  rqi_pkg::rqi_side_t                    in_side,
  output logic                                  out_valid,
  output logic [1:0][COORD_WIDTH-2:0]           out_q,
  output logic [1:0]                            out_ovf,
  output logic [1:0]                            out_neg,
  output rqi_pkg::rqi_side_t                    out_side
);
  import rqi_pkg::*;

  localparam int QW = COORD_WIDTH - 1;
  localparam int NW = NMAG_W + FRAC_BITS;
  localparam int RW = DEN_W + 1;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] lo;
    logic [QW-1:0] q;
    logic          ovf;
    logic          neg;
  } dl_t;

  dl_t              st   [0:QW][0:1];
  logic [DEN_W-1:0] den  [0:QW];
  rqi_side_t        side [0:QW];
  logic [QW:0]      vld;

  // quotient of (mag << FRAC_BITS) / den overflows QW bits iff the top part >= den
  function automatic dl_t dv_first(logic [NMAG_W-1:0] mag, logic neg, logic [DEN_W-1:0] d);
    logic [NW-1:0] n;
    logic [NW-1:0] topx;
    dl_t           f;
    n     = {mag, {FRAC_BITS{1'b0}}};
    topx  = n >> QW;
    f.ovf = topx >= NW'(d);
    f.rem = topx[RW-1:0];
    f.lo  = n[QW-1:0];
    f.q   = '0;
    f.neg = neg;
    return f;
  endfunction

  function automatic dl_t dv_step(dl_t s, logic [DEN_W-1:0] d);
    logic [RW-1:0] r2;
    logic          ge;
    dl_t           n;
    r2    = {s.rem[RW-2:0], s.lo[QW-1]};
    ge    = r2 >= {1'b0, d};
    n     = s;
    n.rem = ge ? r2 - {1'b0, d} : r2;
    n.lo  = s.lo << 1;
    n.q   = {s.q[QW-2:0], ge};
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        st[0][l] <= dv_first(in_mag[l], in_neg[l], in_den);
      end
      den[0]  <= in_den;
      side[0] <= in_side;
      for (int k = 0; k < QW; k++) begin
        for (int l = 0; l < 2; l++) begin
          st[k+1][l] <= dv_step(st[k][l], den[k]);
        end
        den[k+1]  <= den[k];
        side[k+1] <= side[k];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      out_q[l]   = st[QW][l].q;
      out_ovf[l] = st[QW][l].ovf;
      out_neg[l] = st[QW][l].neg;
    end
  end

  assign out_valid = vld[QW];
  assign out_side  = side[QW];

endmodule

[hdl/ray_quadric_intersect_top.sv]
// Ray / sphere, cylinder and cone intersection, fully pipelined.
//
//  channel   dir  words carried
//  ray_in    in   shape select, origin, direction, center, radius
//  hit_out   out  hit, t_near, both roots, discriminant
//
// One word enters per cycle unless hit_out stalls; items pass stages s1 to s9,
// the 64-stage square root, p1, p2 and the COORD_WIDTH-stage root divider.
// rst clears only the valid bits. A stalled hit_out freezes the whole pipeline
// (ray_in.ready drops), so nothing is dropped or duplicated.
`include "ray_quadric_intersect_top_macros.svh"

module ray_quadric_intersect_top #(
  parameter int FRAC_BITS   = rqi_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = rqi_pkg::COORD_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  rqi_ray_if.sink    ray_in,
  rqi_hit_if.source  hit_out
);
  import rqi_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int QW = CW - 1;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int SW = (PW + 3 > COEF_W + 1) ? PW + 3 : COEF_W + 1;

  logic en;

  // stage 1: offsets from the center
  logic                 s1_v;
  rqi_func_t            s1_func;
  logic signed [CW-1:0] s1_vx, s1_vy, s1_vz;
  logic signed [DW-1:0] s1_dx, s1_dy, s1_dz;
  logic [CW-2:0]        s1_rad;

  // stage 2: products
  logic                 s2_v;
  rqi_func_t            s2_func;
  logic signed [PW-1:0] s2_vxx, s2_vyy, s2_vzz, s2_vxd, s2_vyd, s2_vzd;
  logic signed [PW-1:0] s2_dxx, s2_dyy, s2_dzz, s2_rr;

  // stage 3: sums
  logic                 s3_v;
  rqi_func_t            s3_func;
  logic signed [SW-1:0] s3_sa, s3_sb, s3_sc;
  logic signed [SW-1:0] sa_n, sb_n, sc_n, sb_half;

  // stage 4: scaled and clamped coefficients
  logic                     s4_v, s4_nul;
  logic signed [COEF_W-1:0] s4_a, s4_b, s4_c;

  // stage 5: magnitudes
  logic                     s5_v, s5_nul, s5_an, s5_cn;
  logic [MAG_W-1:0]         s5_am, s5_bm, s5_cm;
  logic signed [COEF_W-1:0] s5_a, s5_b;

  // stage 6: partial products
  logic                     s6_v, s6_nul, s6_acn;
  logic [PP_W-1:0]          s6_bll, s6_blh, s6_bhh, s6_all, s6_alh, s6_ahl, s6_ahh;
  logic signed [COEF_W-1:0] s6_a, s6_b;

  // stage 7: b*b and |a*c|
  logic                     s7_v, s7_nul, s7_acn;
  logic [PROD_W-1:0]        s7_bb, s7_ac;
  logic signed [COEF_W-1:0] s7_a, s7_b;

  // stage 8: discriminant
  logic                     s8_v, s8_nul;
  logic signed [DISC_W-1:0] s8_disc;
  logic signed [COEF_W-1:0] s8_a, s8_b;

  // stage 9: saturate, validity, sqrt operand
  logic                         s9_v;
  rqi_side_t                    s9_side;
  logic [RAD_W-1:0]             s9_rad;
  logic signed [OUT_DISC_W-1:0] disc_sat;

  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  rqi_side_t         sq_side;

  logic                    p1_v;
  logic signed [NUM_W-1:0] p1_np, p1_nm;
  logic [MAG_W-1:0]        p1_am;
  rqi_side_t               p1_side;
  logic signed [NUM_W-1:0] sq_s, sq_b;

  logic                    p2_v;
  logic [1:0][NMAG_W-1:0]  p2_mag;
  logic [1:0]              p2_neg;
  logic [DEN_W-1:0]        p2_den;
  rqi_side_t               p2_side;

  logic               dv_v;
  logic [1:0][QW-1:0] dv_q;
  logic [1:0]         dv_ovf, dv_neg;
  rqi_side_t          dv_side;

  logic signed [CW-1:0] rp_c, rm_c, tn_c;
  logic                 hit_c;

  logic                         out_vld, out_hit;
  logic signed [CW-1:0]         out_tn, out_rp, out_rm;
  logic signed [OUT_DISC_W-1:0] out_disc;

  function automatic logic signed [COEF_W-1:0] coef_clamp(logic signed [SW-1:0] s);
    logic signed [SW-1:0] sh;
    sh = s >>> FRAC_BITS;
    if (sh > SW'(COEF_LIM)) return COEF_LIM;
    if (sh < -SW'(COEF_LIM)) return -COEF_LIM;
    return sh[COEF_W-1:0];
  endfunction

  function automatic logic [MAG_W-1:0] coef_mag(logic signed [COEF_W-1:0] v);
    logic signed [COEF_W-1:0] m;
    m = v[COEF_W-1] ? -v : v;
    return m[MAG_W-1:0];
  endfunction

  function automatic logic signed [CW-1:0] root_val(logic [QW-1:0] q, logic ovf, logic neg);
    if (ovf) return neg ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
    return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  assign en           = !out_vld || hit_out.ready;
  assign ray_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0; s4_v <= 1'b0; s5_v <= 1'b0;
      s6_v <= 1'b0; s7_v <= 1'b0; s8_v <= 1'b0; s9_v <= 1'b0;
      p1_v <= 1'b0; p2_v <= 1'b0; out_vld <= 1'b0;
    end else if (en) begin
      s1_v <= ray_in.valid; s2_v <= s1_v; s3_v <= s2_v; s4_v <= s3_v; s5_v <= s4_v;
      s6_v <= s5_v; s7_v <= s6_v; s8_v <= s7_v; s9_v <= s8_v;
      p1_v <= sq_v; p2_v <= p1_v; out_vld <= dv_v;
    end
  end

  always_comb begin
    sa_n    = '0;
    sb_half = '0;
    sc_n    = '0;
    case (s2_func)
      FUNC_SPHERE: begin
        sa_n    = SW'(s2_vxx) + SW'(s2_vzz) + SW'(s2_vyy);
        sb_half = SW'(s2_vxd) + SW'(s2_vzd) + SW'(s2_vyd);
        sc_n    = SW'(s2_dxx) + SW'(s2_dzz) + SW'(s2_dyy) - SW'(s2_rr);
      end
      FUNC_CYL: begin
        sa_n    = SW'(s2_vxx) + SW'(s2_vzz);
        sb_half = SW'(s2_vxd) + SW'(s2_vzd);
        sc_n    = SW'(s2_dxx) + SW'(s2_dzz) - SW'(s2_rr);
      end
      FUNC_CONE: begin
        sa_n    = SW'(s2_vxx) + SW'(s2_vzz) - SW'(s2_vyy);
        sb_half = SW'(s2_vxd) + SW'(s2_vzd) - SW'(s2_vyd);
        sc_n    = SW'(s2_dxx) + SW'(s2_dzz) - SW'(s2_dyy);
      end
      default: begin
        sa_n    = '0;
        sb_half = '0;
        sc_n    = '0;
      end
    endcase
    sb_n = sb_half + sb_half;
  end

  always_comb begin
    if (s8_disc[DISC_W-1:OUT_DISC_W-1] == '0 || s8_disc[DISC_W-1:OUT_DISC_W-1] == '1) begin
      disc_sat = s8_disc[OUT_DISC_W-1:0];
    end else begin
      disc_sat = s8_disc[DISC_W-1] ? {1'b1, {(OUT_DISC_W-1){1'b0}}}
                                   : {1'b0, {(OUT_DISC_W-1){1'b1}}};
    end
  end

  assign sq_s = $signed(NUM_W'(sq_root));
  assign sq_b = NUM_W'(sq_side.b);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_func <= rqi_func_t'(ray_in.func);
      s1_vx   <= ray_in.dir_x;
      s1_vy   <= ray_in.dir_y;
      s1_vz   <= ray_in.dir_z;
      s1_dx   <= DW'(ray_in.origin_x) - DW'(ray_in.center_x);
      s1_dy   <= DW'(ray_in.origin_y) - DW'(ray_in.center_y);
      s1_dz   <= DW'(ray_in.origin_z) - DW'(ray_in.center_z);
      s1_rad  <= ray_in.shape_radius;

      s2_func <= s1_func;
      s2_vxx  <= PW'(s1_vx) * PW'(s1_vx);
      s2_vyy  <= PW'(s1_vy) * PW'(s1_vy);
      s2_vzz  <= PW'(s1_vz) * PW'(s1_vz);
      s2_vxd  <= PW'(s1_vx) * PW'(s1_dx);
      s2_vyd  <= PW'(s1_vy) * PW'(s1_dy);
      s2_vzd  <= PW'(s1_vz) * PW'(s1_dz);
      s2_dxx  <= PW'(s1_dx) * PW'(s1_dx);
      s2_dyy  <= PW'(s1_dy) * PW'(s1_dy);
      s2_dzz  <= PW'(s1_dz) * PW'(s1_dz);
      s2_rr   <= PW'($signed({1'b0, s1_rad})) * PW'($signed({1'b0, s1_rad}));

      s3_func <= s2_func;
      s3_sa   <= sa_n;
      s3_sb   <= sb_n;
      s3_sc   <= sc_n;

      s4_nul <= s3_func == FUNC_NONE;
      s4_a   <= coef_clamp(s3_sa);
      s4_b   <= coef_clamp(s3_sb);
      s4_c   <= coef_clamp(s3_sc);

      s5_nul <= s4_nul;
      s5_am  <= coef_mag(s4_a);
      s5_bm  <= coef_mag(s4_b);
      s5_cm  <= coef_mag(s4_c);
      s5_an  <= s4_a[COEF_W-1];
      s5_cn  <= s4_c[COEF_W-1];
      s5_a   <= s4_a;
      s5_b   <= s4_b;

      // split magnitudes at HALF_W so each multiplier stays narrow
      s6_nul <= s5_nul;
      s6_acn <= s5_an ^ s5_cn;
      s6_bll <= PP_W'(s5_bm[HALF_W-1:0]) * PP_W'(s5_bm[HALF_W-1:0]);
      s6_blh <= PP_W'(s5_bm[HALF_W-1:0]) * PP_W'(s5_bm[MAG_W-1:HALF_W]);
      s6_bhh <= PP_W'(s5_bm[MAG_W-1:HALF_W]) * PP_W'(s5_bm[MAG_W-1:HALF_W]);
      s6_all <= PP_W'(s5_am[HALF_W-1:0]) * PP_W'(s5_cm[HALF_W-1:0]);
      s6_alh <= PP_W'(s5_am[HALF_W-1:0]) * PP_W'(s5_cm[MAG_W-1:HALF_W]);
      s6_ahl <= PP_W'(s5_am[MAG_W-1:HALF_W]) * PP_W'(s5_cm[HALF_W-1:0]);
      s6_ahh <= PP_W'(s5_am[MAG_W-1:HALF_W]) * PP_W'(s5_cm[MAG_W-1:HALF_W]);
      s6_a   <= s5_a;
      s6_b   <= s5_b;

      s7_nul <= s6_nul;
      s7_acn <= s6_acn;
      s7_bb  <= (PROD_W'(s6_bhh) << (2 * HALF_W)) + (PROD_W'(s6_blh) << (HALF_W + 1))
                + PROD_W'(s6_bll);
      s7_ac  <= (PROD_W'(s6_ahh) << (2 * HALF_W))
                + ((PROD_W'(s6_alh) + PROD_W'(s6_ahl)) << HALF_W) + PROD_W'(s6_all);
      s7_a   <= s6_a;
      s7_b   <= s6_b;

      s8_nul  <= s7_nul;
      s8_disc <= s7_acn ? $signed(DISC_W'(s7_bb) + DISC_W'({s7_ac, 2'b00}))
                        : $signed(DISC_W'(s7_bb) - DISC_W'({s7_ac, 2'b00}));
      s8_a    <= s7_a;
      s8_b    <= s7_b;

      s9_side.ok   <= !s8_nul && (s8_a != '0) && !s8_disc[DISC_W-1];
      s9_side.disc <= s8_nul ? '0 : disc_sat;
      s9_side.a    <= s8_a;
      s9_side.b    <= s8_b;
      s9_rad       <= (!s8_nul && (s8_a != '0) && !s8_disc[DISC_W-1])
                      ? s8_disc[RAD_W-1:0] : '0;

      p1_np   <= sq_s - sq_b;
      p1_nm   <= -sq_s - sq_b;
      p1_am   <= coef_mag(sq_side.a);
      p1_side <= sq_side;

      p2_mag[0] <= p1_np[NUM_W-1] ? NMAG_W'(-p1_np) : NMAG_W'(p1_np);
      p2_mag[1] <= p1_nm[NUM_W-1] ? NMAG_W'(-p1_nm) : NMAG_W'(p1_nm);
      p2_neg[0] <= (p1_np != '0) && (p1_np[NUM_W-1] != p1_side.a[COEF_W-1]);
      p2_neg[1] <= (p1_nm != '0) && (p1_nm[NUM_W-1] != p1_side.a[COEF_W-1]);
      p2_den    <= {p1_am, 1'b0};
      p2_side   <= p1_side;

      out_hit  <= dv_side.ok && hit_c;
      out_tn   <= dv_side.ok ? tn_c : '0;
      out_rp   <= dv_side.ok ? rp_c : '0;
      out_rm   <= dv_side.ok ? rm_c : '0;
      out_disc <= dv_side.disc;
    end
  end

  rqi_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s9_v),
    .in_rad    (s9_rad),
    .in_side   (s9_side),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  rqi_div #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p2_v),
    .in_mag    (p2_mag),
    .in_neg    (p2_neg),
    .in_den    (p2_den),
    .in_side   (p2_side),
    .out_valid (dv_v),
    .out_q     (dv_q),
    .out_ovf   (dv_ovf),
    .out_neg   (dv_neg),
    .out_side  (dv_side)
  );

  // nearest strictly positive root
  always_comb begin
    rp_c  = root_val(dv_q[0], dv_ovf[0], dv_neg[0]);
    rm_c  = root_val(dv_q[1], dv_ovf[1], dv_neg[1]);
    hit_c = 1'b0;
    tn_c  = '0;
    if (rp_c > 0) begin
      hit_c = 1'b1;
      tn_c  = rp_c;
    end
    if (rm_c > 0 && (!hit_c || rm_c < tn_c)) begin
      hit_c = 1'b1;
      tn_c  = rm_c;
    end
  end

  assign hit_out.valid        = out_vld;
  assign hit_out.hit          = out_hit;
  assign hit_out.t_near       = out_tn;
  assign hit_out.root_plus    = out_rp;
  assign hit_out.root_minus   = out_rm;
  assign hit_out.discriminant = out_disc;

  `RQI_ASSERT_IMP(a_miss_zero_t, out_vld && !out_hit, out_tn == '0)
  `RQI_ASSERT_IMP(a_hit_is_root, out_vld && out_hit,
                  !out_tn[CW-1] && out_tn != '0 && (out_tn == out_rp || out_tn == out_rm))
  `RQI_ASSERT_IMP(a_neg_disc_miss, out_vld && out_disc[OUT_DISC_W-1],
                  !out_hit && out_rp == '0 && out_rm == '0)
  `RQI_ASSERT_NXT(a_sqrt_operand, en && s8_v, s9_v && (s9_side.ok || s9_rad == '0))

endmodule
